/* hw/rtl/pst_pkg.sv */
// Shared types and constants for the priority scheduler.
// Used by pst_ctrl, pst_dpath and priority_schedule_times; no dependencies.
package pst_pkg;

	localparam int MAX_PROCS = 64;
	localparam int IDX_W     = $clog2(MAX_PROCS);
	localparam int CNT_W     = $clog2(MAX_PROCS + 1);
	localparam int ID_W      = 6;
	localparam int ID_SPAN   = 2 ** ID_W;
	localparam int BURST_W   = 16;
	localparam int PRIO_W    = 8;
	localparam int TIME_W    = 22;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
	} ent_t;

	typedef struct packed {
		logic [TIME_W-1:0] finish;
		logic              has_next;
		logic [IDX_W-1:0]  nxt;
	} link_t;

	typedef enum logic {SRC_IN, SRC_CAND} src_t;
	typedef enum logic [1:0] {RSEL_CTL, RSEL_HEAD, RSEL_NEXT} rsel_t;
	typedef enum logic {HSEL_ENT, HSEL_V} hsel_t;

	typedef struct packed {
		logic             ent_we;
		src_t             ent_wsrc;
		logic [IDX_W-1:0] ent_waddr;
		rsel_t            ent_rsel;
		logic [IDX_W-1:0] ent_raddr;
		logic             cand_ld;
		logic             tot_add;
		logic             tot_clr;
		logic             acc_init;
		logic             link_cap;
		hsel_t            head_rsel;
		logic [ID_W-1:0]  head_v;
		logic             link_we;
		logic [IDX_W-1:0] link_addr;
		logic             hv_clr;
		logic             out_ld;
	} cmd_t;

	typedef struct packed {
		logic swap;
		logic hv_v;
		logic has_next;
	} sts_t;

endpackage

/* hw/rtl/pst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* hw/rtl/pst_dpath.sv */
// Datapath of the priority scheduler: job, link and id-head memories,
// candidate register, time accumulator and output registers. Uses pst_pkg, pst_ram.
module pst_dpath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pst_pkg::cmd_t           cmd,
	output pst_pkg::sts_t           sts,
	input  logic [pst_pkg::ID_W-1:0]    job_id,
	input  logic [pst_pkg::BURST_W-1:0] burst_time,
	input  logic [pst_pkg::PRIO_W-1:0]  prio_level,
	output logic [pst_pkg::ID_W-1:0]    out_id,
	output logic [pst_pkg::BURST_W-1:0] out_burst,
	output logic [pst_pkg::PRIO_W-1:0]  out_prio,
	output logic [pst_pkg::TIME_W-1:0]  finish_time,
	output logic [pst_pkg::TIME_W-1:0]  wait_time
);
	import pst_pkg::*;

	ent_t               ent_wdata, ent_rdata, cand_q;
	logic [IDX_W-1:0]   ent_raddr;
	link_t              link_wdata, link_rdata;
	logic [ID_W-1:0]    head_raddr, lid_q;
	logic [IDX_W-1:0]   head_rdata, nxt_q;
	logic [ID_SPAN-1:0] hv_q;
	logic [TIME_W-1:0]  tot_q, acc_q;
	logic [BURST_W-1:0] lburst_q;
	logic               nxt_ok_q;

	assign ent_wdata = (cmd.ent_wsrc == SRC_IN) ? ent_t'{job_id, burst_time, prio_level}
	                                            : cand_q;

	always_comb begin
		case (cmd.ent_rsel)
			RSEL_CTL:  ent_raddr = cmd.ent_raddr;
			RSEL_HEAD: ent_raddr = head_rdata;
			RSEL_NEXT: ent_raddr = nxt_q;
			default:   ent_raddr = cmd.ent_raddr;
		endcase
	end

	assign head_raddr = (cmd.head_rsel == HSEL_V) ? cmd.head_v : ent_rdata.id;

	assign link_wdata = link_t'{acc_q, hv_q[lid_q], head_rdata};

	pst_ram #(.WIDTH($bits(ent_t)), .DEPTH(MAX_PROCS)) u_ent_ram (
		.clk     (clk),
		.wr_en   (cmd.ent_we),
		.wr_addr (cmd.ent_waddr),
		.wr_data (ent_wdata),
		.rd_addr (ent_raddr),
		.rd_data (ent_rdata)
	);

	pst_ram #(.WIDTH($bits(link_t)), .DEPTH(MAX_PROCS)) u_link_ram (
		.clk     (clk),
		.wr_en   (cmd.link_we),
		.wr_addr (cmd.link_addr),
		.wr_data (link_wdata),
		.rd_addr (ent_raddr),
		.rd_data (link_rdata)
	);

	pst_ram #(.WIDTH(IDX_W), .DEPTH(ID_SPAN)) u_head_ram (
		.clk     (clk),
		.wr_en   (cmd.link_we),
		.wr_addr (lid_q),
		.wr_data (cmd.link_addr),
		.rd_addr (head_raddr),
		.rd_data (head_rdata)
	);

	// Head valid bits and batch total are control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q  <= '0;
			tot_q <= '0;
		end else begin
			if (cmd.hv_clr) begin
				hv_q <= '0;
			end else if (cmd.link_we) begin
				hv_q[lid_q] <= 1'b1;
			end
			if (cmd.tot_clr) begin
				tot_q <= '0;
			end else if (cmd.tot_add) begin
				tot_q <= tot_q + TIME_W'(burst_time);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cand_ld) begin
			cand_q <= ent_rdata;
		end
		// Finish times are built back to front: start at the batch total.
		if (cmd.acc_init) begin
			acc_q <= tot_q;
		end else if (cmd.link_we) begin
			acc_q <= acc_q - TIME_W'(lburst_q);
		end
		if (cmd.link_cap) begin
			lid_q    <= ent_rdata.id;
			lburst_q <= ent_rdata.burst;
		end
		if (cmd.out_ld) begin
			out_id      <= ent_rdata.id;
			out_burst   <= ent_rdata.burst;
			out_prio    <= ent_rdata.prio;
			finish_time <= link_rdata.finish;
			wait_time   <= link_rdata.finish - TIME_W'(ent_rdata.burst);
			nxt_q       <= link_rdata.nxt;
			nxt_ok_q    <= link_rdata.has_next;
		end
	end

	assign sts.swap     = (cand_q.prio > ent_rdata.prio);
	assign sts.hv_v     = hv_q[cmd.head_v];
	assign sts.has_next = nxt_ok_q;

endmodule

/* hw/rtl/pst_ctrl.sv */
// Controller of the priority scheduler: load, exchange sort, link build and
// emit sequencing. Uses pst_pkg; drives pst_dpath through cmd_t and sts_t.
module pst_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          last_job,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          out_last,
	output pst_pkg::cmd_t cmd,
	input  pst_pkg::sts_t sts
);
	import pst_pkg::*;

	typedef enum logic [3:0] {
		ST_LOAD, ST_ROW, ST_CAND, ST_SCAN, ST_END,
		ST_LREAD, ST_LHEAD, ST_LWRITE,
		ST_ESCAN, ST_EHEAD, ST_EDATA, ST_EOUT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q, k_q, cnt_new;
	logic [IDX_W-1:0] i_q, jc_q, p_q;
	logic [ID_W-1:0]  v_q;
	logic             store, in_acc, out_acc;

	assign in_ready = (state_q == ST_LOAD);
	assign in_acc   = in_valid & in_ready;
	assign out_acc  = out_valid & out_ready;
	assign store    = (cnt_q < CNT_W'(MAX_PROCS));
	assign cnt_new  = store ? cnt_q + CNT_W'(1) : cnt_q;

	always_comb begin
		cmd           = '0;
		cmd.ent_wsrc  = SRC_CAND;
		cmd.ent_rsel  = RSEL_CTL;
		cmd.head_rsel = HSEL_ENT;
		cmd.head_v    = v_q;
		cmd.link_addr = p_q;
		case (state_q)
			ST_LOAD: begin
				cmd.ent_wsrc  = SRC_IN;
				cmd.ent_waddr = cnt_q[IDX_W-1:0];
				cmd.ent_we    = in_acc & store;
				cmd.tot_add   = in_acc & store;
			end
			ST_ROW: begin
				cmd.ent_raddr = i_q;
			end
			ST_CAND: begin
				cmd.cand_ld   = 1'b1;
				cmd.ent_raddr = i_q + IDX_W'(1);
			end
			ST_SCAN: begin
				cmd.ent_we    = sts.swap;
				cmd.ent_waddr = jc_q;
				cmd.cand_ld   = sts.swap;
				cmd.ent_raddr = jc_q + IDX_W'(1);
			end
			ST_END: begin
				cmd.ent_we    = 1'b1;
				cmd.ent_waddr = i_q;
			end
			ST_LREAD: begin
				cmd.acc_init  = 1'b1;
				cmd.ent_raddr = p_q;
			end
			ST_LHEAD: begin
				cmd.link_cap = 1'b1;
			end
			ST_LWRITE: begin
				cmd.link_we   = 1'b1;
				cmd.ent_raddr = p_q - IDX_W'(1);
			end
			ST_ESCAN: begin
				cmd.head_rsel = HSEL_V;
			end
			ST_EHEAD: begin
				cmd.ent_rsel = RSEL_HEAD;
			end
			ST_EDATA: begin
				cmd.out_ld = 1'b1;
			end
			ST_EOUT: begin
				cmd.ent_rsel = RSEL_NEXT;
				cmd.hv_clr   = out_acc & out_last;
				cmd.tot_clr  = out_acc & out_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			k_q       <= '0;
			i_q       <= '0;
			jc_q      <= '0;
			p_q       <= '0;
			v_q       <= '0;
			out_valid <= 1'b0;
			out_last  <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						cnt_q <= cnt_new;
						if (last_job) begin
							i_q <= '0;
							p_q <= IDX_W'(cnt_new - CNT_W'(1));
							state_q <= (cnt_new >= CNT_W'(2)) ? ST_ROW : ST_LREAD;
						end
					end
				end
				ST_ROW: begin
					state_q <= ST_CAND;
				end
				ST_CAND: begin
					jc_q    <= i_q + IDX_W'(1);
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (CNT_W'(jc_q) == cnt_q - CNT_W'(1)) begin
						state_q <= ST_END;
					end else begin
						jc_q <= jc_q + IDX_W'(1);
					end
				end
				ST_END: begin
					if (CNT_W'(i_q) + CNT_W'(2) < cnt_q) begin
						i_q     <= i_q + IDX_W'(1);
						state_q <= ST_ROW;
					end else begin
						p_q     <= IDX_W'(cnt_q - CNT_W'(1));
						state_q <= ST_LREAD;
					end
				end
				ST_LREAD: begin
					state_q <= ST_LHEAD;
				end
				ST_LHEAD: begin
					state_q <= ST_LWRITE;
				end
				ST_LWRITE: begin
					if (p_q == '0) begin
						v_q     <= '0;
						k_q     <= '0;
						state_q <= ST_ESCAN;
					end else begin
						p_q     <= p_q - IDX_W'(1);
						state_q <= ST_LHEAD;
					end
				end
				ST_ESCAN: begin
					if (sts.hv_v) begin
						state_q <= ST_EHEAD;
					end else begin
						v_q <= v_q + ID_W'(1);
					end
				end
				ST_EHEAD: begin
					state_q <= ST_EDATA;
				end
				ST_EDATA: begin
					out_valid <= 1'b1;
					out_last  <= (k_q + CNT_W'(1) == cnt_q);
					state_q   <= ST_EOUT;
				end
				ST_EOUT: begin
					if (out_acc) begin
						out_valid <= 1'b0;
						k_q       <= k_q + CNT_W'(1);
						if (out_last) begin
							cnt_q   <= '0;
							state_q <= ST_LOAD;
						end else if (sts.has_next) begin
							state_q <= ST_EDATA;
						end else begin
							v_q     <= v_q + ID_W'(1);
							state_q <= ST_ESCAN;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/priority_schedule_times.sv */
// Top level of the non-preemptive priority scheduler.
// Depends on pst_pkg, pst_ctrl, pst_dpath and pst_ram.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+--------------------------------------------------
//  in      | in_valid / in_ready  | job_id, burst_time, prio_level, last_job
//  out     | out_valid / out_ready| out_id, out_burst, out_prio, finish_time,
//          |                      | wait_time, out_last
//
// Jobs are accepted while loading. The last one of a batch of two or more jobs starts
// the exchange sort over the job RAM, one row after another. Then the finish times and
// per-id chains are built back to front. Results come out by ascending id; the emitter
// steps past every unused id below the largest id in the batch.
// Reset clears only the control state; the RAMs need no clearing pass.
// in_ready is high only while loading; a result holds on the outputs until taken.
module priority_schedule_times (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [pst_pkg::ID_W-1:0]    job_id,
	input  logic [pst_pkg::BURST_W-1:0] burst_time,
	input  logic [pst_pkg::PRIO_W-1:0]  prio_level,
	input  logic                        last_job,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [pst_pkg::ID_W-1:0]    out_id,
	output logic [pst_pkg::BURST_W-1:0] out_burst,
	output logic [pst_pkg::PRIO_W-1:0]  out_prio,
	output logic [pst_pkg::TIME_W-1:0]  finish_time,
	output logic [pst_pkg::TIME_W-1:0]  wait_time,
	output logic                        out_last
);
	import pst_pkg::*;

	// Command and status between the sequencer and the datapath.
	cmd_t cmd;
	sts_t sts;

	// Sequence load, sort, chain build and emit; hold each result until taken.
	pst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_job  (last_job),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_last  (out_last),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Store jobs, swap them by priority, accumulate finish times and
	// chain equal ids in scheduled order so results come out by ascending id.
	pst_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.job_id      (job_id),
		.burst_time  (burst_time),
		.prio_level  (prio_level),
		.out_id      (out_id),
		.out_burst   (out_burst),
		.out_prio    (out_prio),
		.finish_time (finish_time),
		.wait_time   (wait_time)
	);

endmodule
